>>> rtl/bf_interpreter_core_macros.svh
// Assertion macros for the tape-machine core.
`ifndef BF_INTERPRETER_CORE_MACROS_SVH
`define BF_INTERPRETER_CORE_MACROS_SVH

`ifndef SYNTH
`define BFI_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bfi assertion failed");
`define BFI_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bfi forbidden condition seen");
`else
`define BFI_ASSERT(label, clk, rst_n, prop)
`define BFI_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

>>> rtl/bfi_pkg.sv
// Types, sizes and character codes of the tape-machine core.
package bfi_pkg;

  localparam int unsigned PROG_DEPTH = 4096;
  localparam int unsigned CELL_COUNT = 32768;

  localparam int unsigned PA_W = $clog2(PROG_DEPTH);
  localparam int unsigned PL_W = $clog2(PROG_DEPTH + 1);
  localparam int unsigned CA_W = $clog2(CELL_COUNT);

  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_EOF   = 8'hFF;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] prog_char;
    logic [7:0] input_char;
  } in_t;

  typedef struct packed {
    logic              out_valid;
    logic signed [7:0] out_value;
    logic              input_used;
    logic              halted;
    logic              load_overflow;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_CELL_RD,
    ST_CELL_LD,
    ST_SCAN_ADR,
    ST_SCAN_CHK,
    ST_FIN
  } state_e;

endpackage

>>> rtl/bfi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bfi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/bf_interpreter_core.sv
// Tape-machine core: program store, cell store and instruction sequencer.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------
//   item in  | start, busy          | item_i (in_t)
//   result   | done_o (one cycle)   | result_o (out_t)
//
// A load or a halted step passes through ST_FIN to the registered result.
// Data ops pass through ST_EXEC and ST_FIN; pointer moves add ST_CELL_RD and
// ST_CELL_LD (cell store reread). A bracket scan alternates ST_SCAN_ADR and
// ST_SCAN_CHK per program character visited, one more ST_SCAN_ADR when it
// runs off either end, one program store read per character through the
// shared index stepper. After reset a clearing pass zeroes all CELL_COUNT
// (32768) cells with busy high. The result strobe cannot be stalled; busy
// is already low in the strobe cycle, so the next transfer may start there.
module bf_interpreter_core
  import bfi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  item_i,
  output logic done_o,
  output out_t result_o
);

`include "bf_interpreter_core_macros.svh"

  state_e state_q, state_d;

  logic [CA_W-1:0] clr_q, clr_d;
  logic [PL_W-1:0] len_q, len_d;
  logic [PL_W-1:0] pc_q, pc_d;
  logic [CA_W-1:0] ptr_q, ptr_d;
  logic [7:0]      cell_q, cell_d;
  logic [PL_W-1:0] idx_q, idx_d;
  logic [PL_W-1:0] depth_q, depth_d;
  logic            dir_q, dir_d;
  logic [7:0]      ichar_q, ichar_d;
  logic            outv_q, outv_d;
  logic            used_q, used_d;
  logic            ovf_q, ovf_d;
  logic            done_q, done_d;
  out_t            result_q, result_d;

  logic            accept;
  logic [7:0]      instr;
  logic [PL_W-1:0] idx_next;
  logic            scan_end;
  logic [PL_W-1:0] depth_next;
  logic [CA_W-1:0] ptr_inc, ptr_dec;

  logic            prog_we;
  logic [PA_W-1:0] prog_raddr;
  logic            cell_we;
  logic [CA_W-1:0] cell_waddr;
  logic [7:0]      cell_wdata;
  logic [7:0]      cell_rdata;

  localparam logic [CA_W-1:0] CELL_LAST = CA_W'(CELL_COUNT - 1);

  bfi_ram #(
    .WIDTH (8),
    .DEPTH (PROG_DEPTH)
  ) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (len_q[PA_W-1:0]),
    .wdata_i (item_i.prog_char),
    .raddr_i (prog_raddr),
    .rdata_o (instr)
  );

  bfi_ram #(
    .WIDTH (8),
    .DEPTH (CELL_COUNT)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .raddr_i (ptr_q),
    .rdata_o (cell_rdata)
  );

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // shared index stepper for bracket scans
  assign idx_next = dir_q ? (idx_q + PL_W'(1)) : (idx_q - PL_W'(1));
  assign scan_end = dir_q ? (idx_next >= len_q) : (idx_q == '0);

  always_comb begin
    depth_next = depth_q;
    if (instr == (dir_q ? CH_OPEN : CH_CLOSE)) begin
      depth_next = depth_q + PL_W'(1);
    end else if (instr == (dir_q ? CH_CLOSE : CH_OPEN)) begin
      depth_next = depth_q - PL_W'(1);
    end
  end

  assign ptr_inc = (ptr_q == CELL_LAST) ? '0 : (ptr_q + CA_W'(1));
  assign ptr_dec = (ptr_q == '0) ? CELL_LAST : (ptr_q - CA_W'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == CELL_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (item_i.op == OP_STEP && pc_q < len_q) state_d = ST_EXEC;
          else state_d = ST_FIN;
        end
      end
      ST_EXEC: begin
        if (instr inside {CH_RIGHT, CH_LEFT}) begin
          state_d = ST_CELL_RD;
        end else if (instr == CH_OPEN && cell_q == '0) begin
          state_d = ST_SCAN_ADR;
        end else if (instr == CH_CLOSE && cell_q != '0) begin
          state_d = ST_SCAN_ADR;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_CELL_RD:  state_d = ST_CELL_LD;
      ST_CELL_LD:  state_d = ST_FIN;
      ST_SCAN_ADR: state_d = scan_end ? ST_FIN : ST_SCAN_CHK;
      ST_SCAN_CHK: state_d = (depth_next == '0) ? ST_FIN : ST_SCAN_ADR;
      ST_FIN:      state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_d      = clr_q;
    len_d      = len_q;
    pc_d       = pc_q;
    ptr_d      = ptr_q;
    cell_d     = cell_q;
    idx_d      = idx_q;
    depth_d    = depth_q;
    dir_d      = dir_q;
    ichar_d    = ichar_q;
    outv_d     = outv_q;
    used_d     = used_q;
    ovf_d      = ovf_q;
    done_d     = 1'b0;
    result_d   = result_q;
    prog_we    = 1'b0;
    prog_raddr = pc_q[PA_W-1:0];
    cell_we    = 1'b0;
    cell_waddr = ptr_q;
    cell_wdata = cell_d;

    case (state_q)
      ST_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_q;
        cell_wdata = '0;
        clr_d      = clr_q + CA_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          ichar_d = item_i.input_char;
          outv_d  = 1'b0;
          used_d  = 1'b0;
          ovf_d   = 1'b0;
          if (item_i.op == OP_LOAD && item_i.prog_char != CH_NL &&
              item_i.prog_char != CH_EOF) begin
            if (len_q < PL_W'(PROG_DEPTH)) begin
              prog_we = 1'b1;
              len_d   = len_q + PL_W'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
      end
      ST_EXEC: begin
        pc_d = pc_q + PL_W'(1);
        case (instr)
          CH_RIGHT: ptr_d = ptr_inc;
          CH_LEFT:  ptr_d = ptr_dec;
          CH_INC: begin
            cell_d  = cell_q + 8'd1;
            cell_we = 1'b1;
          end
          CH_DEC: begin
            cell_d  = cell_q - 8'd1;
            cell_we = 1'b1;
          end
          CH_OUT: outv_d = 1'b1;
          CH_IN: begin
            cell_d  = ichar_q - CH_ZERO;
            cell_we = 1'b1;
            used_d  = 1'b1;
          end
          CH_OPEN: begin
            if (cell_q == '0) begin
              pc_d    = pc_q;
              idx_d   = pc_q;
              depth_d = PL_W'(1);
              dir_d   = 1'b1;
            end
          end
          CH_CLOSE: begin
            if (cell_q != '0) begin
              pc_d    = pc_q;
              idx_d   = pc_q;
              depth_d = PL_W'(1);
              dir_d   = 1'b0;
            end
          end
          default: ;
        endcase
        cell_wdata = cell_d;
      end
      ST_CELL_RD: ;
      ST_CELL_LD: cell_d = cell_rdata;
      ST_SCAN_ADR: begin
        if (scan_end) begin
          pc_d = dir_q ? len_q : (pc_q + PL_W'(1));
        end else begin
          idx_d      = idx_next;
          prog_raddr = idx_next[PA_W-1:0];
        end
      end
      ST_SCAN_CHK: begin
        depth_d = depth_next;
        if (depth_next == '0) begin
          pc_d = dir_q ? (idx_q + PL_W'(1)) : idx_q;
        end
      end
      ST_FIN: begin
        done_d                 = 1'b1;
        result_d.out_valid     = outv_q;
        result_d.out_value     = signed'(cell_q);
        result_d.input_used    = used_q;
        result_d.halted        = (pc_q >= len_q);
        result_d.load_overflow = ovf_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      len_q   <= '0;
      pc_q    <= '0;
      ptr_q   <= '0;
      cell_q  <= '0;
      idx_q   <= '0;
      depth_q <= '0;
      dir_q   <= 1'b0;
      outv_q  <= 1'b0;
      used_q  <= 1'b0;
      ovf_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      len_q   <= len_d;
      pc_q    <= pc_d;
      ptr_q   <= ptr_d;
      cell_q  <= cell_d;
      idx_q   <= idx_d;
      depth_q <= depth_d;
      dir_q   <= dir_d;
      outv_q  <= outv_d;
      used_q  <= used_d;
      ovf_q   <= ovf_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ichar_q  <= ichar_d;
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `BFI_ASSERT(a_done_single, clk_i, rst_ni, done_o |=> !done_o)
  `BFI_ASSERT_NEVER(a_pc_in_range, clk_i, rst_ni, pc_q > len_q)
  `BFI_ASSERT(a_halt_flag, clk_i, rst_ni, done_o |-> (result_o.halted == (pc_q >= len_q)))
  `BFI_ASSERT(a_ovf_full, clk_i, rst_ni,
              (done_o && result_o.load_overflow) |-> (len_q == PL_W'(PROG_DEPTH)))

endmodule

>>> tb/sv/bf_interpreter_core_tb.sv
// Testbench for the tape-machine core: directed and random programs against a local predictor.
module bf_interpreter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfi_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  in_t  item_i = '0;
  logic busy;
  logic done_o;
  out_t result_o;

  bf_interpreter_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // machine state as the predictor sees it
  logic [7:0]  prog_mem [PROG_DEPTH];
  logic [7:0]  cell_mem [CELL_COUNT];
  int unsigned prog_len = 0;
  int unsigned prog_pc = 0;
  int unsigned cell_ptr = 0;

  out_t expected_results [$];
  out_t oldest;
  int   n_errors = 0;
  int   items_sent = 0;
  bit   sender_pauses = 1'b1;

  function automatic out_t predict_step(in_t it);
    out_t        r;
    logic [7:0]  c;
    int unsigned depth;
    int unsigned i;
    bit          advance;
    bit          ran_off;
    r = '0;
    if (it.op == OP_LOAD) begin
      if (it.prog_char != CH_NL && it.prog_char != CH_EOF) begin
        if (prog_len < PROG_DEPTH) begin
          prog_mem[prog_len] = it.prog_char;
          prog_len++;
        end else begin
          r.load_overflow = 1'b1;
        end
      end
    end else if (prog_pc < prog_len) begin
      c = prog_mem[prog_pc];
      advance = 1'b1;
      case (c)
        CH_RIGHT: cell_ptr = (cell_ptr == CELL_COUNT - 1) ? 0 : cell_ptr + 1;
        CH_LEFT:  cell_ptr = (cell_ptr == 0) ? CELL_COUNT - 1 : cell_ptr - 1;
        CH_INC:   cell_mem[cell_ptr] = cell_mem[cell_ptr] + 8'd1;
        CH_DEC:   cell_mem[cell_ptr] = cell_mem[cell_ptr] - 8'd1;
        CH_OUT:   r.out_valid = 1'b1;
        CH_IN: begin
          cell_mem[cell_ptr] = it.input_char - CH_ZERO;
          r.input_used = 1'b1;
        end
        CH_OPEN: begin
          if (cell_mem[cell_ptr] == 8'h00) begin
            advance = 1'b0;
            depth = 1;
            i = prog_pc;
            ran_off = 1'b0;
            while (depth != 0 && !ran_off) begin
              i++;
              if (i >= prog_len) ran_off = 1'b1;
              else if (prog_mem[i] == CH_OPEN) depth++;
              else if (prog_mem[i] == CH_CLOSE) depth--;
            end
            prog_pc = ran_off ? prog_len : i + 1;
          end
        end
        CH_CLOSE: begin
          if (cell_mem[cell_ptr] != 8'h00) begin
            advance = 1'b0;
            depth = 1;
            i = prog_pc;
            ran_off = 1'b0;
            while (depth != 0 && !ran_off) begin
              if (i == 0) begin
                ran_off = 1'b1;
              end else begin
                i--;
                if (prog_mem[i] == CH_CLOSE) depth++;
                else if (prog_mem[i] == CH_OPEN) depth--;
              end
            end
            prog_pc = ran_off ? prog_pc + 1 : i;
          end
        end
        default: ;
      endcase
      if (advance) prog_pc++;
    end
    r.out_value = cell_mem[cell_ptr];
    r.halted = (prog_pc >= prog_len);
    return r;
  endfunction

  function automatic logic [7:0] plain_op(int unsigned sel);
    case (sel)
      0:       return CH_RIGHT;
      1:       return CH_LEFT;
      2:       return CH_INC;
      3:       return CH_DEC;
      4:       return CH_OUT;
      default: return CH_IN;
    endcase
  endfunction

  // mostly digits, so that counted loops stay short
  function automatic logic [7:0] pick_input_char();
    if ($urandom_range(99) < 70) return 8'($urandom_range(57, 48));
    return 8'($urandom_range(255));
  endfunction

  task automatic send_item(input in_t it);
    if (sender_pauses && $urandom_range(99) < 19) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_results = {expected_results, predict_step(it)};
    items_sent++;
  endtask

  task automatic load_char(input logic [7:0] ch);
    in_t it;
    it.op = OP_LOAD;
    it.prog_char = ch;
    it.input_char = 8'($urandom_range(255));
    send_item(it);
  endtask

  task automatic step_once(input logic [7:0] ic);
    in_t it;
    it.op = OP_STEP;
    it.prog_char = 8'($urandom_range(255));
    it.input_char = ic;
    send_item(it);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no expectation: %p", result_o);
        n_errors++;
      end else begin
        oldest = expected_results.pop_front();
        if (result_o.out_valid !== oldest.out_valid) begin
          $error("out_valid: expected %0b, actual %0b", oldest.out_valid, result_o.out_valid);
          n_errors++;
        end
        if (result_o.out_value !== oldest.out_value) begin
          $error("out_value: expected %0d, actual %0d", oldest.out_value, result_o.out_value);
          n_errors++;
        end
        if (result_o.input_used !== oldest.input_used) begin
          $error("input_used: expected %0b, actual %0b", oldest.input_used,
                 result_o.input_used);
          n_errors++;
        end
        if (result_o.halted !== oldest.halted) begin
          $error("halted: expected %0b, actual %0b", oldest.halted, result_o.halted);
          n_errors++;
        end
        if (result_o.load_overflow !== oldest.load_overflow) begin
          $error("load_overflow: expected %0b, actual %0b", oldest.load_overflow,
                 result_o.load_overflow);
          n_errors++;
        end
      end
    end
  end

  // empty program, dropped newline and EOF, NUL as a no-op
  task automatic test_halted_step();
    step_once(8'($urandom_range(255)));
    load_char(CH_NL);
    load_char(CH_EOF);
    load_char(8'h00);
    step_once(8'($urandom_range(255)));
  endtask

  // reads at both input extremes, pointer wrap in both directions, output of a negative cell
  task automatic test_basic_ops();
    load_char(CH_IN);
    load_char(CH_LEFT);
    load_char(CH_IN);
    load_char(CH_OUT);
    load_char(CH_RIGHT);
    load_char(CH_INC);
    step_once(8'h00);
    step_once(pick_input_char());
    step_once(8'hFF);
    step_once(pick_input_char());
    step_once(pick_input_char());
    step_once(pick_input_char());
  endtask

  // unmatched close on nonzero, matched skip on zero, unmatched open, load after halt
  task automatic test_brackets();
    load_char(CH_CLOSE);
    step_once(pick_input_char());
    load_char(CH_RIGHT);
    load_char(CH_OPEN);
    load_char(CH_INC);
    load_char(CH_CLOSE);
    load_char(CH_OPEN);
    repeat (3) step_once(pick_input_char());
    load_char(CH_INC);
    step_once(pick_input_char());
  endtask

  task automatic test_random_programs();
    logic [7:0] chunk [$];
    in_t        raw;
    int         n;
    int         s;
    while (items_sent < 460) begin
      sender_pauses = !(items_sent >= 200 && items_sent < 350);
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(4, 1)) begin
          raw.op = op_e'($urandom_range(1));
          raw.prog_char = 8'($urandom_range(255));
          raw.input_char = 8'($urandom_range(255));
          send_item(raw);
        end
      end
      chunk.delete();
      n = $urandom_range(16, 3);
      for (int k = 0; k < n; k++) begin
        s = $urandom_range(99);
        if (s < 15) begin
          // counted loop: only the loop cell's own decrement touches it
          chunk = {chunk, CH_OPEN};
          chunk = {chunk, CH_DEC};
          repeat ($urandom_range(3, 1)) begin
            chunk = {chunk, CH_RIGHT};
            chunk = {chunk, plain_op($urandom_range(5, 2))};
            chunk = {chunk, CH_LEFT};
          end
          chunk = {chunk, CH_CLOSE};
        end else if (s < 20) begin
          chunk = {chunk, 8'($urandom_range(255))};
        end else begin
          chunk = {chunk, plain_op($urandom_range(5))};
        end
      end
      foreach (chunk[k]) load_char(chunk[k]);
      repeat ($urandom_range(3 * chunk.size(), chunk.size())) step_once(pick_input_char());
    end
    sender_pauses = 1'b1;
  endtask

  // dropped codes and random appends after a long program, then more steps
  task automatic test_dropped_loads();
    load_char(CH_NL);
    load_char(CH_EOF);
    load_char(CH_INC);
    repeat (8) load_char(8'($urandom_range(255)));
    repeat (8) step_once(pick_input_char());
  endtask

  initial begin
    foreach (cell_mem[k]) cell_mem[k] = 8'h00;
    foreach (prog_mem[k]) prog_mem[k] = 8'h00;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_halted_step();
    test_basic_ops();
    test_brackets();
    test_random_programs();
    test_dropped_loads();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
